/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion helpers for the converter checker
// Concurrent assertion shorthands, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define EVC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("converter assertion failed");

// Condition must never be seen outside reset
`define EVC_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("converter forbidden condition seen");

`endif

/* src/evc_pkg.sv */
// ----------------------------------------------------------------------------
// evc_pkg
// Shared widths, codes, types and helpers of the Euler variable converter.
// ----------------------------------------------------------------------------
`default_nettype none

package evc_pkg;

  localparam int DATA_W        = 32;
  localparam int GAMMA_W       = 31;
  localparam int DIV_W         = 64;               // dividend and quotient
  localparam int DIVR_W        = DATA_W + 1;       // divisor, holds twice the density
  localparam int PROD_W        = 2 * DATA_W;
  localparam int WIDE_W        = 3 * DATA_W;
  localparam int CFG_IDX_W     = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_COMP      = 3;
  localparam int NUM_LANES     = NUM_COMP + 1;
  localparam int KIN_CAP_EXP   = 60;
  localparam int KIN_W         = KIN_CAP_EXP + 1;
  localparam int PM_CAP_EXP    = 40;
  localparam int PH_W          = KIN_W - DATA_W + GAMMA_W;
  localparam int EVC_LATENCY   = DIV_W + 6;

  localparam logic [1:0]         DIMS_RESET  = 2'd3;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(26214);

  localparam logic [DIV_W-1:0] POS_MAX = (DIV_W'(1) << (DATA_W - 1)) - DIV_W'(1);
  localparam logic [DIV_W-1:0] NEG_MAG = DIV_W'(1) << (DATA_W - 1);
  localparam logic [KIN_W-1:0] KIN_CAP = KIN_W'(1) << KIN_CAP_EXP;
  localparam logic [DIV_W-1:0] PM_CAP  = DIV_W'(1) << PM_CAP_EXP;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION  = 8'd0,
    REG_DIMENSIONS = 8'd1,
    REG_GAMMA      = 8'd2
  } cfg_reg_t;

  typedef enum logic {
    DIR_P2C = 1'b0,
    DIR_C2P = 1'b1
  } dir_t;

  typedef struct packed {
    logic sat;
    logic [DATA_W-1:0] val;
  } sres_t;

  typedef struct packed {
    logic                             v;
    dir_t                             dir;
    logic [NUM_COMP-1:0]              used;
    logic [GAMMA_W-1:0]               g;
    logic [DATA_W-1:0]                rho;
    logic [NUM_COMP-1:0][DATA_W-1:0]  comp;
    logic [DATA_W-1:0]                last;
  } item_t;

  typedef struct packed {
    item_t                it;
    sres_t [NUM_COMP-1:0] mo;
    logic [KIN_W-1:0]     kin;
  } side_t;

  // Magnitude of a two's complement word; the most negative value maps to 2^31
  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? (DATA_W'(0) - x) : x;
  endfunction

  // Apply sign to a magnitude and clip to the 32-bit signed range
  function automatic sres_t sat_signed(input logic neg, input logic [DIV_W-1:0] mag);
    sres_t r;
    logic [DIV_W-1:0] negv;
    negv = DIV_W'(0) - mag;
    if (!neg) begin
      if (mag > POS_MAX) begin
        r.sat = 1'b1;
        r.val = POS_MAX[DATA_W-1:0];
      end else begin
        r.sat = 1'b0;
        r.val = mag[DATA_W-1:0];
      end
    end else begin
      if (mag > NEG_MAG) begin
        r.sat = 1'b1;
        r.val = NEG_MAG[DATA_W-1:0];
      end else begin
        r.sat = 1'b0;
        r.val = negv[DATA_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/evc_div.sv */
// ----------------------------------------------------------------------------
// evc_div
// Four-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module evc_div
  import evc_pkg::*;
(
  input  logic                              clk,
  input  logic [NUM_LANES-1:0][DIV_W-1:0]   dividend,
  input  logic [NUM_LANES-1:0][DIVR_W-1:0]  divisor,
  output logic [NUM_LANES-1:0][DIV_W-1:0]   quotient
);

  logic [DIVR_W-1:0] rem [DIV_W][NUM_LANES];
  logic [DIV_W-1:0]  nq  [DIV_W][NUM_LANES];
  logic [DIVR_W-1:0] dv  [DIV_W][NUM_LANES];

  for (genvar s = 0; s < DIV_W; s++) begin : g_stage
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [DIVR_W-1:0] rem_in;
      logic [DIVR_W-1:0] dv_in;
      logic [DIV_W-1:0]  nq_in;
      logic [DIVR_W:0]   trial;
      logic              take;

      if (s == 0) begin : g_first
        assign rem_in = '0;
        assign nq_in  = dividend[l];
        assign dv_in  = divisor[l];
      end else begin : g_next
        assign rem_in = rem[s-1][l];
        assign nq_in  = nq[s-1][l];
        assign dv_in  = dv[s-1][l];
      end

      // dividend bits leave at the top while quotient bits enter at the bottom
      assign trial = {rem_in, nq_in[DIV_W-1]};
      assign take  = trial >= {1'b0, dv_in};

      always_ff @(posedge clk) begin
        rem[s][l] <= take ? DIVR_W'(trial - {1'b0, dv_in}) : DIVR_W'(trial);
        nq[s][l]  <= {nq_in[DIV_W-2:0], take};
        dv[s][l]  <= dv_in;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) quotient[l] = nq[DIV_W-1][l];
  end

endmodule

`default_nettype wire

/* src/euler_variable_conversion.sv */
// ----------------------------------------------------------------------------
// euler_variable_conversion
// Done strobes once a taken request has passed stages 1 to 3, the 64-stage
// divider that yields quotient bits one per stage, and stages E, F and G.
// Throughput: one request per cycle; busy is high in reset and for one cycle
// after it, and low otherwise. The receiver cannot stall.
// Reset: synchronous, clears the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_variable_conversion
  import evc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] density_in,
  input  logic signed [DATA_W-1:0] comp_x_in,
  input  logic signed [DATA_W-1:0] comp_y_in,
  input  logic signed [DATA_W-1:0] comp_z_in,
  input  logic signed [DATA_W-1:0] last_var_in,
  output logic                     done,
  output logic signed [DATA_W-1:0] density_out,
  output logic signed [DATA_W-1:0] comp_x_out,
  output logic signed [DATA_W-1:0] comp_y_out,
  output logic signed [DATA_W-1:0] comp_z_out,
  output logic signed [DATA_W-1:0] last_var_out,
  output logic                     saturated,
  output logic                     bad_density,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  localparam int DLY = DIV_W - 2;
  localparam int KIN_SHIFT = 2 * FRAC_BITS + 1;
  localparam logic [PROD_W-1:0] M_RND   = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [WIDE_W-1:0] KIN_RND = WIDE_W'(1) << (2 * FRAC_BITS);
  localparam logic [WIDE_W-1:0] PM_RND  = WIDE_W'(1) << (FRAC_BITS - 1);

  // configuration
  dir_t               dir_q;
  logic [1:0]         dims_q;
  logic [GAMMA_W-1:0] gamma_q;
  logic               take;

  assign take      = start && !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      dir_q   <= DIR_P2C;
      dims_q  <= DIMS_RESET;
      gamma_q <= GAMMA_RESET;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DIRECTION:  dir_q   <= dir_t'(cfg_data[0]);
          REG_DIMENSIONS: dims_q  <= cfg_data[1:0];
          REG_GAMMA:      gamma_q <= cfg_data[GAMMA_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // stage 1: capture request
  item_t      st1, st1_next;
  logic [1:0] dims_eff;

  always_comb begin
    dims_eff      = (dims_q == 2'd0) ? 2'd1 : dims_q;
    st1_next.v    = take;
    st1_next.dir  = dir_q;
    for (int i = 0; i < NUM_COMP; i++) st1_next.used[i] = 2'(i) < dims_eff;
    st1_next.g    = (gamma_q == '0) ? GAMMA_W'(1) : gamma_q;
    st1_next.rho  = density_in;
    st1_next.comp = {comp_z_in, comp_y_in, comp_x_in};
    st1_next.last = last_var_in;
  end

  always_ff @(posedge clk) begin
    if (rst) st1.v <= 1'b0;
    else     st1 <= st1_next;
  end

  // stage 2: momentum products and squares
  item_t                           st2;
  logic [NUM_COMP-1:0][PROD_W-1:0] prod2, prod2_next, sq2, sq2_next;
  logic [NUM_COMP-1:0][DATA_W-1:0] um1;
  logic [DATA_W-1:0]               rm1;

  always_comb begin
    rm1 = mag32(st1.rho);
    for (int i = 0; i < NUM_COMP; i++) begin
      um1[i]        = mag32(st1.comp[i]);
      prod2_next[i] = PROD_W'(rm1) * PROD_W'(um1[i]);
      sq2_next[i]   = st1.used[i] ? PROD_W'(um1[i]) * PROD_W'(um1[i]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st2.v <= 1'b0;
    end else begin
      st2   <= st1;
      prod2 <= prod2_next;
      sq2   <= sq2_next;
    end
  end

  // stage 3: sum of squares, rounded momenta
  item_t                           st3;
  logic [PROD_W-1:0]               sum3, sum3_next;
  sres_t [NUM_COMP-1:0]            mo3, mo3_next;
  logic [NUM_COMP-1:0][PROD_W-1:0] mrnd;

  always_comb begin
    sum3_next = '0;
    for (int i = 0; i < NUM_COMP; i++) begin
      sum3_next   = sum3_next + sq2[i];
      mrnd[i]     = prod2[i] + M_RND;
      mo3_next[i] = sat_signed(st2.rho[DATA_W-1] ^ st2.comp[i][DATA_W-1],
                               DIV_W'(mrnd[i] >> FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st3.v <= 1'b0;
    end else begin
      st3  <= st2;
      sum3 <= sum3_next;
      mo3  <= mo3_next;
    end
  end

  // stage 4: kinetic partial products; divider operands
  item_t                              st4;
  sres_t [NUM_COMP-1:0]               mo4;
  logic [PROD_W-1:0]                  kp_lo4, kp_hi4, kp_lo4_next, kp_hi4_next;
  logic [DATA_W-1:0]                  rm3;
  logic [NUM_LANES-1:0][DIV_W-1:0]    dvd;
  logic [NUM_LANES-1:0][DIVR_W-1:0]   dvs;
  logic [NUM_LANES-1:0][DIV_W-1:0]    quot;

  always_comb begin
    rm3         = mag32(st3.rho);
    kp_lo4_next = PROD_W'(rm3) * PROD_W'(sum3[DATA_W-1:0]);
    kp_hi4_next = PROD_W'(rm3) * PROD_W'(sum3[PROD_W-1:DATA_W]);
    for (int i = 0; i < NUM_COMP; i++) begin
      dvd[i] = (DIV_W'(mag32(st3.comp[i])) << FRAC_BITS) + DIV_W'(st3.rho >> 1);
      dvs[i] = DIVR_W'(st3.rho);
    end
    if (st3.dir == DIR_P2C) begin
      dvd[NUM_COMP] = (DIV_W'(mag32(st3.last)) << FRAC_BITS) + DIV_W'(st3.g >> 1);
      dvs[NUM_COMP] = DIVR_W'(st3.g);
    end else begin
      dvd[NUM_COMP] = sum3 + DIV_W'(st3.rho);
      dvs[NUM_COMP] = {st3.rho, 1'b0};
    end
  end

  evc_div u_div (
    .clk      (clk),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st4.v <= 1'b0;
    end else begin
      st4    <= st3;
      mo4    <= mo3;
      kp_lo4 <= kp_lo4_next;
      kp_hi4 <= kp_hi4_next;
    end
  end

  // stage 5: kinetic term for the primitive direction
  item_t                st5;
  sres_t [NUM_COMP-1:0] mo5;
  logic [KIN_W-1:0]     kin5, kin5_next;
  logic [WIDE_W-1:0]    kfull, kshift;

  always_comb begin
    kfull     = (WIDE_W'(kp_hi4) << DATA_W) + WIDE_W'(kp_lo4) + KIN_RND;
    kshift    = kfull >> KIN_SHIFT;
    kin5_next = (kshift > WIDE_W'(KIN_CAP)) ? KIN_CAP : kshift[KIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st5.v <= 1'b0;
    end else begin
      st5  <= st4;
      mo5  <= mo4;
      kin5 <= kin5_next;
    end
  end

  // hold side data level with the divider
  side_t dl [DLY];
  side_t dl_in;

  assign dl_in = '{it: st5, mo: mo5, kin: kin5};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DLY; k++) dl[k].it.v <= 1'b0;
    end else begin
      dl[0] <= dl_in;
      for (int k = 1; k < DLY; k++) dl[k] <= dl[k-1];
    end
  end

  // stage E: components, energy, pressure difference
  side_t                           sd;
  logic [DIV_W-1:0]                kin64, pt_s, kn_s, esum, emag, kin1;
  sres_t [NUM_COMP-1:0]            cr;
  logic [NUM_COMP-1:0][DATA_W-1:0] co_next;
  logic                            csat_next, bad_next;
  sres_t                           eo_next;
  logic [DIV_W-1:0]                diff_next;

  logic                            ve;
  dir_t                            dir_e;
  logic                            bad_e, csat_e;
  logic [DATA_W-1:0]               rho_e;
  logic [NUM_COMP-1:0][DATA_W-1:0] co_e;
  sres_t                           eo_e;
  logic [DIV_W-1:0]                diff_e;
  logic [GAMMA_W-1:0]              g_e;

  always_comb begin
    sd        = dl[DLY-1];
    kin64     = DIV_W'(sd.kin);
    pt_s      = sd.it.last[DATA_W-1] ? (DIV_W'(0) - quot[NUM_COMP]) : quot[NUM_COMP];
    kn_s      = sd.it.rho[DATA_W-1] ? (DIV_W'(0) - kin64) : kin64;
    esum      = pt_s + kn_s;
    emag      = esum[DIV_W-1] ? (DIV_W'(0) - esum) : esum;
    eo_next   = sat_signed(esum[DIV_W-1], emag);
    kin1      = (quot[NUM_COMP] > DIV_W'(KIN_CAP)) ? DIV_W'(KIN_CAP) : quot[NUM_COMP];
    diff_next = {{(DIV_W - DATA_W){sd.it.last[DATA_W-1]}}, sd.it.last} - kin1;
    bad_next  = (sd.it.dir == DIR_C2P) && (sd.it.rho[DATA_W-1] || (sd.it.rho == '0));
    csat_next = 1'b0;
    for (int i = 0; i < NUM_COMP; i++) begin
      cr[i] = (sd.it.dir == DIR_P2C) ? sd.mo[i] : sat_signed(sd.it.comp[i][DATA_W-1], quot[i]);
      if (sd.it.used[i]) begin
        co_next[i] = cr[i].val;
        csat_next  = csat_next | cr[i].sat;
      end else begin
        co_next[i] = sd.it.comp[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else begin
      ve     <= sd.it.v;
      dir_e  <= sd.it.dir;
      bad_e  <= bad_next;
      rho_e  <= sd.it.rho;
      co_e   <= co_next;
      csat_e <= csat_next;
      eo_e   <= eo_next;
      diff_e <= diff_next;
      g_e    <= sd.it.g;
    end
  end

  // stage F: pressure partial products
  logic                            dneg;
  logic [DIV_W-1:0]                dabs;
  logic [PROD_W-1:0]               pl_next;
  logic [PH_W-1:0]                 ph_next;

  logic                            vf;
  dir_t                            dir_f;
  logic                            bad_f, csat_f, dneg_f;
  logic [DATA_W-1:0]               rho_f;
  logic [NUM_COMP-1:0][DATA_W-1:0] co_f;
  sres_t                           eo_f;
  logic [PROD_W-1:0]               pl_f;
  logic [PH_W-1:0]                 ph_f;

  always_comb begin
    dneg    = diff_e[DIV_W-1];
    dabs    = dneg ? (DIV_W'(0) - diff_e) : diff_e;
    pl_next = PROD_W'(dabs[DATA_W-1:0]) * PROD_W'(g_e);
    ph_next = PH_W'(dabs[KIN_W-1:DATA_W]) * PH_W'(g_e);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else begin
      vf     <= ve;
      dir_f  <= dir_e;
      bad_f  <= bad_e;
      csat_f <= csat_e;
      dneg_f <= dneg;
      rho_f  <= rho_e;
      co_f   <= co_e;
      eo_f   <= eo_e;
      pl_f   <= pl_next;
      ph_f   <= ph_next;
    end
  end

  // stage G: round pressure, select, output register
  logic [WIDE_W-1:0] pfull, pshift;
  logic [DIV_W-1:0]  pm;
  sres_t             po, lastsel;

  always_comb begin
    pfull   = (WIDE_W'(ph_f) << DATA_W) + WIDE_W'(pl_f) + PM_RND;
    pshift  = pfull >> FRAC_BITS;
    pm      = (pshift > WIDE_W'(PM_CAP)) ? PM_CAP : pshift[DIV_W-1:0];
    po      = sat_signed(dneg_f, pm);
    lastsel = (dir_f == DIR_P2C) ? eo_f : po;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      saturated   <= 1'b0;
      bad_density <= 1'b0;
    end else begin
      done        <= vf;
      saturated   <= vf && !bad_f && (csat_f || lastsel.sat);
      bad_density <= vf && bad_f;
      // drop every value on a bad density
      if (bad_f) begin
        density_out  <= '0;
        comp_x_out   <= '0;
        comp_y_out   <= '0;
        comp_z_out   <= '0;
        last_var_out <= '0;
      end else begin
        density_out  <= rho_f;
        comp_x_out   <= co_f[0];
        comp_y_out   <= co_f[1];
        comp_z_out   <= co_f[2];
        last_var_out <= lastsel.val;
      end
    end
  end

endmodule

`default_nettype wire

/* src/evc_checker.sv */
// ----------------------------------------------------------------------------
// evc_checker
// Port-level checks of the converter: fixed latency, result flags and zeroed outputs on a bad density.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module evc_checker
  import evc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [DATA_W-1:0] density_out,
  input logic [DATA_W-1:0] comp_x_out,
  input logic [DATA_W-1:0] comp_y_out,
  input logic [DATA_W-1:0] comp_z_out,
  input logic [DATA_W-1:0] last_var_out,
  input logic              saturated,
  input logic              bad_density
);

  `EVC_ASSERT(a_req_done, clk, rst, start && !busy |-> ##EVC_LATENCY done)
  `EVC_ASSERT(a_no_req_no_done, clk, rst, !(start && !busy) |-> ##EVC_LATENCY !done)
  `EVC_ASSERT(a_bad_zero, clk, rst, done && bad_density |-> !saturated && density_out == '0 && comp_x_out == '0 && comp_y_out == '0 && comp_z_out == '0 && last_var_out == '0)
  `EVC_NEVER(a_flag_alone, clk, rst, (saturated || bad_density) && !done)

endmodule

bind euler_variable_conversion evc_checker u_evc_checker (.*);

`default_nettype wire
